FILE: src/rftr_pkg.sv
// rftr_pkg: shared types and constants for the receive FIFO with timed read.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package rftr_pkg;

   // Request kinds carried in the req_type field
   typedef enum logic [1:0] {
      REQ_BYTE  = 2'd0,   // received byte
      REQ_READ  = 2'd1,   // read request with tick timeout
      REQ_TICK  = 2'd2,   // time tick
      REQ_FLUSH = 2'd3    // empty the ring
   } req_kind_type;

   // Result status codes
   localparam logic STATUS_DATA    = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   // Field widths
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TICKS_W = 32;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [TICKS_W-1:0] ticks_type;

   // Timeout value that never expires
   localparam ticks_type FOREVER_TIMEOUT = 32'hFFFF_FFFF;

endpackage

FILE: src/rftr_if.sv
// rftr_if: valid/ready channel interfaces for requests and results.
// Depends on rftr_pkg for the field types.
`timescale 1ns / 1ps

// Request channel: kind, received byte, read timeout
interface rftr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [rftr_pkg::KIND_W-1:0]           req_type;
   rftr_pkg::byte_type                    rx_byte;
   rftr_pkg::ticks_type                   timeout_ticks;

   modport source (output valid, output req_type, output rx_byte, output timeout_ticks,
                   input ready);
   modport sink   (input valid, input req_type, input rx_byte, input timeout_ticks,
                   output ready);
endinterface

// Result channel: delivered byte and status
interface rftr_rsp_if;
   logic                 valid;
   logic                 ready;
   rftr_pkg::byte_type   read_byte;
   logic                 read_status;

   modport source (output valid, output read_byte, output read_status, input ready);
   modport sink   (input valid, input read_byte, input read_status, output ready);
endinterface

FILE: src/rx_fifo_timed_read_unit.sv
// rx_fifo_timed_read_unit: receive byte FIFO with a timed blocking read.
// Depends on rftr_pkg, rftr_req_if / rftr_rsp_if and rftr_ram.
`timescale 1ns / 1ps

// Usage
//   req_ch carries one transaction per request: a received byte, a read
//   request with a tick timeout, a time tick, or a flush. rsp_ch returns
//   at most one result per request: a byte with status 0, or a zero byte
//   with status 1 when a pending read timed out.
//   Bytes live in a RING_DEPTH entry ring memory that keeps one slot
//   empty; a byte arriving on a full ring is dropped. A read on an empty
//   ring parks until a byte arrives (handed straight over) or the tick
//   count exceeds the timeout; all-ones waits forever.
//   Throughput: one request per cycle while the result register has room; a
//   ring read also holds off requests in ST_READ (registered ring read port).
//   The result register loads in the cycle after the request, except that a
//   ring read passes through the ring read register and ST_READ first.
//   A request is taken only when the result register is empty or drained
//   in the same cycle, so a stalled receiver holds off further requests.
//   Reset (synchronous) empties the ring and drops any pending read; the
//   ring contents are not cleared and need no clearing pass.
module rx_fifo_timed_read_unit #(
   parameter int unsigned RING_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   rftr_req_if.sink    req_ch,
   rftr_rsp_if.source  rsp_ch
);

   import rftr_pkg::*;

   localparam int unsigned AW = $clog2(RING_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef logic [AW-1:0] ptr_type;

   state_type state_ff, state_in;
   ptr_type   wp_ff, wp_in;
   ptr_type   rp_ff, rp_in;
   logic      waiting_ff, waiting_in;
   ticks_type elapsed_ff, elapsed_in;
   ticks_type pending_ff, pending_in;
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  read_byte_ff, read_byte_in;
   logic      read_status_ff, read_status_in;

   logic      req_ready;
   logic      req_accept;
   logic      ram_we;
   logic      ram_re;
   byte_type  ram_rdata;
   ptr_type   wp_next;
   ptr_type   rp_next;
   ticks_type elapsed_next;

   assign wp_next      = wp_ff + ptr_type'(1);
   assign rp_next      = rp_ff + ptr_type'(1);
   assign elapsed_next = (elapsed_ff == FOREVER_TIMEOUT) ? elapsed_ff
                                                         : elapsed_ff + ticks_type'(1);

   // take a request only in idle with room in the result register
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept = req_ch.valid && req_ready;

   // ring memory: write at wp, read at rp
   rftr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_ch.rx_byte),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   // next-state logic
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      rp_in          = rp_ff;
      waiting_in     = waiting_ff;
      elapsed_in     = elapsed_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      read_byte_in   = read_byte_ff;
      read_status_in = read_status_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (state_ff == ST_READ) begin
         // ring data arrives from the registered read port in the cycle after the read
         rsp_valid_in   = 1'b1;
         read_byte_in   = ram_rdata;
         read_status_in = STATUS_DATA;
         state_in       = ST_IDLE;
      end else if (req_accept) begin
         unique case (req_kind_type'(req_ch.req_type))
            REQ_BYTE: begin
               if (wp_next != rp_ff) begin
                  ram_we = 1'b1;
                  wp_in  = wp_next;
                  if (waiting_ff) begin
                     // empty ring: hand the byte straight to the reader
                     rp_in          = rp_next;
                     waiting_in     = 1'b0;
                     rsp_valid_in   = 1'b1;
                     read_byte_in   = req_ch.rx_byte;
                     read_status_in = STATUS_DATA;
                  end
               end
            end
            REQ_READ: begin
               if (!waiting_ff) begin
                  if (wp_ff != rp_ff) begin
                     ram_re   = 1'b1;
                     rp_in    = rp_next;
                     state_in = ST_READ;
                  end else begin
                     waiting_in = 1'b1;
                     elapsed_in = '0;
                     pending_in = req_ch.timeout_ticks;
                  end
               end
            end
            REQ_TICK: begin
               if (waiting_ff) begin
                  elapsed_in = elapsed_next;
                  if (pending_ff != FOREVER_TIMEOUT && elapsed_next > pending_ff) begin
                     waiting_in     = 1'b0;
                     rsp_valid_in   = 1'b1;
                     read_byte_in   = '0;
                     read_status_in = STATUS_TIMEOUT;
                  end
               end
            end
            REQ_FLUSH: begin
               if (!waiting_ff) begin
                  rp_in = wp_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         waiting_ff   <= 1'b0;
         elapsed_ff   <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         waiting_ff   <= waiting_in;
         elapsed_ff   <= elapsed_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      read_byte_ff   <= read_byte_in;
      read_status_ff <= read_status_in;
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_byte   = read_byte_ff;
   assign rsp_ch.read_status = read_status_ff;

   // a pending read only exists on an empty ring
   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (wp_ff == rp_ff))
      else $error("reader waiting on a non-empty ring");

   // the ring read state lasts exactly one cycle
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("ring read state did not return to idle");

   // the result register is free when ring data lands
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result register busy during ring read");

   // a timeout result carries a zero byte
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (read_status_ff == STATUS_TIMEOUT)) |-> (read_byte_ff == '0))
      else $error("timeout result with nonzero byte");

endmodule

FILE: src/rftr_ram.sv
// rftr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rftr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for rx_fifo_timed_read_unit (receive FIFO, timed read).
// Depends on rftr_pkg and the rftr_req_if / rftr_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import rftr_pkg::*;

   localparam int unsigned RING_DEPTH  = 256;
   localparam int unsigned IDX_W       = $clog2(RING_DEPTH);
   localparam int          CLK_PERIOD  = 10;
   localparam int          ITEM_TARGET = 1700;
   localparam int          IDLE_LIMIT  = 3000;   // cycles with no transaction on either side
   localparam int          HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int          TAIL_CYCLES = 8;

   typedef struct {
      byte_type data;
      logic     status;
   } read_result_type;

   // Scoreboard: ring predictor plus the queue of reads still owed to the reader
   class rx_fifo_scoreboard;
      byte_type         ring [RING_DEPTH];
      logic [IDX_W-1:0] wr_ptr;
      logic [IDX_W-1:0] rd_ptr;
      bit               waiting;
      ticks_type        elapsed;
      ticks_type        wait_limit;
      read_result_type  owed_reads [$];
      int               errors;

      function new();
         foreach (ring[i]) ring[i] = '0;
         wr_ptr     = '0;
         rd_ptr     = '0;
         waiting    = 1'b0;
         elapsed    = '0;
         wait_limit = '0;
         errors     = 0;
      endfunction

      function void owe(byte_type data, logic status);
         read_result_type r;
         r.data   = data;
         r.status = status;
         owed_reads.push_back(r);
      endfunction

      // Advance the ring state for one accepted request transaction
      function void note_request(req_kind_type kind, byte_type data, ticks_type ticks);
         case (kind)
            REQ_BYTE: begin
               if (IDX_W'(wr_ptr + 1'b1) != rd_ptr) begin
                  ring[wr_ptr] = data;
                  wr_ptr       = wr_ptr + 1'b1;
                  // parked reader takes the byte straight away
                  if (waiting) begin
                     owe(ring[rd_ptr], STATUS_DATA);
                     rd_ptr  = rd_ptr + 1'b1;
                     waiting = 1'b0;
                  end
               end
            end
            REQ_READ: begin
               if (!waiting) begin
                  if (wr_ptr != rd_ptr) begin
                     owe(ring[rd_ptr], STATUS_DATA);
                     rd_ptr = rd_ptr + 1'b1;
                  end else begin
                     waiting    = 1'b1;
                     elapsed    = '0;
                     wait_limit = ticks;
                  end
               end
            end
            REQ_TICK: begin
               if (waiting) begin
                  if (elapsed != '1) elapsed = elapsed + 1'b1;
                  if (wait_limit != FOREVER_TIMEOUT && elapsed > wait_limit) begin
                     owe('0, STATUS_TIMEOUT);
                     waiting = 1'b0;
                  end
               end
            end
            REQ_FLUSH: begin
               if (!waiting) rd_ptr = wr_ptr;
            end
         endcase
      endfunction

      // Compare one accepted result transaction with the oldest owed read
      function void check_result(byte_type data, logic status);
         read_result_type want;
         if (owed_reads.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual byte %02h status %0d",
                     $time, data, status);
            errors++;
            return;
         end
         want = owed_reads.pop_front();
         if (data !== want.data) begin
            $display("%0t: read_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, data);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: read_status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return owed_reads.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rftr_req_if req_ch ();
   rftr_rsp_if rsp_ch ();

   rx_fifo_timed_read_unit #(.RING_DEPTH(RING_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rx_fifo_scoreboard sb = new();

   int burst_left = 0;
   int items_sent = 0;
   bit hold_req   = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Monitors on both channels
   always @(posedge clock) begin
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
         sb.note_request(req_kind_type'(req_ch.req_type), req_ch.rx_byte,
                         req_ch.timeout_ticks);
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_result(rsp_ch.read_byte, rsp_ch.read_status);
   end

   // Watchdog: too long without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: random ready pattern, plus one long hold-off on request
   initial begin
      int pct;
      int left;
      pct  = 100;
      left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (left == 0) begin
               case ($urandom_range(0, 3))
                  0: pct = 100;
                  1: pct = 80;
                  2: pct = 50;
                  default: pct = 15;
               endcase
               left = $urandom_range(10, 80);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) < pct);
            left--;
         end
      end
   end

   // Send one request transaction; bursts of random length with gaps between
   task automatic send_item(req_kind_type kind, byte_type data, ticks_type ticks);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                 : $urandom_range(40, 120);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= kind;
      req_ch.rx_byte       <= data;
      req_ch.timeout_ticks <= ticks;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_byte(byte_type data);
      send_item(REQ_BYTE, data, $urandom);
   endtask

   task automatic send_read(ticks_type ticks);
      send_item(REQ_READ, byte_type'($urandom), ticks);
   endtask

   task automatic send_tick();
      send_item(REQ_TICK, byte_type'($urandom), $urandom);
   endtask

   task automatic send_flush();
      send_item(REQ_FLUSH, byte_type'($urandom), $urandom);
   endtask

   // Sender pauses until every owed read has been returned
   task automatic wait_reads_returned();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly short timeouts so waits expire; some forever and some huge
   function automatic ticks_type pick_timeout();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return ticks_type'($urandom_range(0, 4));
      if (r == 6) return FOREVER_TIMEOUT;
      if (r == 7) return FOREVER_TIMEOUT - 1;
      return $urandom;
   endfunction

   // Bytes followed by reads that drain them and possibly park on an empty ring
   task automatic run_stream();
      int n;
      n = $urandom_range(1, 12);
      repeat (n) begin
         send_byte(byte_type'($urandom));
         if ($urandom_range(0, 3) == 0) send_tick();
      end
      repeat ($urandom_range(1, n + 2)) send_read(pick_timeout());
      repeat ($urandom_range(0, 4)) send_tick();
   endtask

   // Empty ring, parked read, ticks, maybe a late byte
   task automatic run_wait();
      send_flush();
      send_read(pick_timeout());
      if ($urandom_range(0, 3) == 0) send_read(pick_timeout());
      if ($urandom_range(0, 5) == 0) send_flush();
      repeat ($urandom_range(0, 6)) send_tick();
      if ($urandom_range(0, 1)) send_byte(byte_type'($urandom));
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 10))
         send_item(req_kind_type'($urandom_range(0, 3)), byte_type'($urandom), $urandom);
   endtask

   // Fill past full so bytes drop, then drain by reads or by flush
   task automatic run_fill(bit by_reads);
      send_flush();
      repeat (RING_DEPTH + 2) send_byte(byte_type'($urandom));
      if (by_reads) begin
         repeat (RING_DEPTH) send_read(ticks_type'($urandom_range(0, 3)));
         repeat (5) send_tick();
      end else begin
         send_flush();
         send_read(ticks_type'(1));
         repeat (2) send_tick();
      end
   endtask

   // Stimulus and end of run
   initial begin
      int seg;
      int r;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = '0;
      req_ch.rx_byte       = '0;
      req_ch.timeout_ticks = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle tick, zero timeout, ignored read/flush while parked
      send_tick();
      send_read(ticks_type'(0));
      send_read(ticks_type'(5));
      send_flush();
      send_tick();
      // Forever wait ended by a byte
      send_read(FOREVER_TIMEOUT);
      repeat (3) send_tick();
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_read(ticks_type'(0));
      send_read(ticks_type'(0));
      // Timeout needs ticks strictly past the limit
      send_read(ticks_type'(2));
      repeat (3) send_tick();
      // Flush discards held bytes; near-forever wait ended by a byte
      send_byte(8'h5A);
      send_byte(8'h81);
      send_flush();
      send_read(FOREVER_TIMEOUT - 1);
      send_tick();
      send_byte(8'h3C);
      send_read(ticks_type'(1));
      repeat (2) send_tick();
      wait_reads_returned();

      // Random part
      seg = 0;
      while (items_sent < ITEM_TARGET) begin
         if (seg == 4) begin
            run_fill(1'b1);
         end else if (seg == 15) begin
            // long receiver stall while the sender keeps offering bytes and reads
            hold_req = 1'b1;
            repeat (24) send_byte(byte_type'($urandom));
            repeat (24) send_read(pick_timeout());
         end else if (seg == 30) begin
            run_fill(1'b0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45)      run_stream();
            else if (r < 75) run_wait();
            else if (r < 94) run_noise();
            else             wait_reads_returned();
         end
         seg++;
      end

      wait_reads_returned();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
src/rftr_pkg.sv
src/rftr_if.sv
src/rftr_ram.sv
src/rx_fifo_timed_read_unit.sv
sim/tb.sv
